/* rtl/rnna_pkg.sv */
// ----------------------------------------------------------------------------
// rnna_pkg
// Shared types, codes and character constants for the recovery name number
// allocator, with the decimal digit helpers used to build a file name.
// ----------------------------------------------------------------------------
package rnna_pkg;

    localparam int KIND_W = 2;
    localparam int NUM_W  = 14;
    localparam int NAME_W = 64;
    localparam int EXT_W  = 24;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [3:0]        digit_t;

    localparam kind_t KIND_SCAN  = 2'd0;
    localparam kind_t KIND_MARK  = 2'd1;
    localparam kind_t KIND_ALLOC = 2'd2;

    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    localparam num_t PLACE_THOUSANDS = 14'd1000;
    localparam num_t PLACE_HUNDREDS  = 14'd100;
    localparam num_t PLACE_TENS      = 14'd10;
    localparam num_t PLACE_UNITS     = 14'd1;

    // Weight of the decimal digit at a given position, most significant first.
    function automatic num_t dec_place(input logic [1:0] pos);
        num_t p;
        begin
            unique case (pos)
                2'd0: p = PLACE_THOUSANDS;
                2'd1: p = PLACE_HUNDREDS;
                2'd2: p = PLACE_TENS;
                default: p = PLACE_UNITS;
            endcase
            return p;
        end
    endfunction

    // Decimal digit of a remainder below ten times the place weight.
    function automatic digit_t dec_digit(input num_t rem, input num_t place);
        digit_t cnt;
        begin
            cnt = 4'd0;
            for (int k = 1; k <= 9; k++) begin
                if (rem >= NUM_W'(k) * place) begin
                    cnt = cnt + 4'd1;
                end
            end
            return cnt;
        end
    endfunction

endpackage

/* rtl/rnna_ram.sv */
// ----------------------------------------------------------------------------
// rnna_ram
// Generic single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module rnna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 313,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/recovery_name_number_allocator_unit.sv */
// ----------------------------------------------------------------------------
// recovery_name_number_allocator_unit
// Used-number bitmap for recovery file names FILEnnnn.CHK, held in one word
// memory. Directory names and direct marks set bits; allocation finds the
// lowest clear number from one upward and returns it with its ASCII name.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_       in         kind, entry_name, entry_ext, mark_number
//  m_       out        name_matched, alloc_ok, chosen_number, chosen_name
//
//  After reset the memory is cleared word by word before any transaction.
//  A matching scan or an in-range mark passes the decode, divide, read,
//  write and response states; any other scan or mark, and kind three, go
//  from decode to response. An allocation reads words until one holds a
//  clear bit, then converts it to four digits, or stops at the last word.
//  A new transaction is taken while the previous result waits on m_ready.
// ----------------------------------------------------------------------------
module recovery_name_number_allocator_unit #(
    parameter int MAX_NUMBER = 9999,
    parameter int WORD_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rnna_pkg::KIND_W-1:0]   s_kind,
    input  logic [rnna_pkg::NAME_W-1:0]   s_entry_name,
    input  logic [rnna_pkg::EXT_W-1:0]    s_entry_ext,
    input  logic [rnna_pkg::NUM_W-1:0]    s_mark_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_name_matched,
    output logic                          m_alloc_ok,
    output logic [rnna_pkg::NUM_W-1:0]    m_chosen_number,
    output logic [rnna_pkg::NAME_W-1:0]   m_chosen_name
);

    import rnna_pkg::*;

    localparam int NUM_WORDS = MAX_NUMBER / WORD_BITS + 1;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(NUM_WORDS + 1);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int LAST_BIT  = MAX_NUMBER - (NUM_WORDS - 1) * WORD_BITS;
    localparam int RSH       = 24;
    localparam int RECIP     = (1 << RSH) / WORD_BITS + 1;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PW        = NUM_W + RECIP_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_CONV,
        ST_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               avail_reg, avail_next;
    logic               m_valid_reg, m_valid_next;

    kind_t              kind_reg, kind_next;
    logic [NAME_W-1:0]  name_reg, name_next;
    logic [EXT_W-1:0]   ext_reg, ext_next;
    num_t               mark_reg, mark_next;
    num_t               num_reg, num_next;
    logic               hit_reg, hit_next;
    logic               found_reg, found_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [AW-1:0]      widx_reg, widx_next;
    logic [BW-1:0]      bit_reg, bit_next;
    logic [CW-1:0]      scan_addr_reg, scan_addr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [AW-1:0]      chk_addr_reg, chk_addr_next;
    logic [1:0]         dcnt_reg, dcnt_next;
    num_t               rem_reg, rem_next;
    digit_t             dig_reg [4];
    digit_t             dig_next [4];

    logic               out_matched_reg, out_matched_next;
    logic               out_ok_reg, out_ok_next;
    num_t               out_num_reg, out_num_next;
    logic [NAME_W-1:0]  out_name_reg, out_name_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [7:0]         nb [8];
    logic [7:0]         eb [3];
    logic               form_ok;
    num_t               dec_value;
    logic [AW-1:0]      widx_calc;
    num_t               bit_calc;
    logic [WORD_BITS-1:0] free_bits;
    logic               zero_found;
    logic [BW-1:0]      zero_idx;
    num_t               place;
    digit_t             digit;

    rnna_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            nb[i] = name_reg[8*i +: 8];
        end
        for (int i = 0; i < 3; i++) begin
            eb[i] = ext_reg[8*i +: 8];
        end
        form_ok = (nb[0] == CH_F) && (nb[1] == CH_I) && (nb[2] == CH_L) &&
                  (nb[3] == CH_E) && (eb[0] == CH_C) && (eb[1] == CH_H) &&
                  (eb[2] == CH_K);
        for (int i = 4; i < 8; i++) begin
            if ((nb[i] < CH_0) || (nb[i] > CH_9)) begin
                form_ok = 1'b0;
            end
        end
        dec_value = NUM_W'(PLACE_THOUSANDS * NUM_W'(nb[4][3:0])) +
                    NUM_W'(PLACE_HUNDREDS * NUM_W'(nb[5][3:0])) +
                    NUM_W'(PLACE_TENS * NUM_W'(nb[6][3:0])) +
                    NUM_W'(nb[7][3:0]);
    end

    always_comb begin
        widx_calc = prod_reg[RSH +: AW];
        bit_calc  = num_reg - NUM_W'(NUM_W'(widx_calc) * NUM_W'(WORD_BITS));
    end

    always_comb begin
        free_bits = ~ram_rdata;
        if (chk_addr_reg == '0) begin
            free_bits[0] = 1'b0;
        end
        if (chk_addr_reg == LAST_ADDR) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i > LAST_BIT) begin
                    free_bits[i] = 1'b0;
                end
            end
        end
        zero_found = |free_bits;
        zero_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                zero_idx = BW'(i);
            end
        end
    end

    always_comb begin
        place = dec_place(dcnt_reg);
        digit = dec_digit(rem_reg, place);
    end

    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        avail_next       = avail_reg;
        m_valid_next     = m_valid_reg;
        kind_next        = kind_reg;
        name_next        = name_reg;
        ext_next         = ext_reg;
        mark_next        = mark_reg;
        num_next         = num_reg;
        hit_next         = hit_reg;
        found_next       = found_reg;
        prod_next        = prod_reg;
        widx_next        = widx_reg;
        bit_next         = bit_reg;
        scan_addr_next   = scan_addr_reg;
        chk_valid_next   = 1'b0;
        chk_addr_next    = chk_addr_reg;
        dcnt_next        = dcnt_reg;
        rem_next         = rem_reg;
        dig_next         = dig_reg;
        out_matched_next = out_matched_reg;
        out_ok_next      = out_ok_reg;
        out_num_next     = out_num_reg;
        out_name_next    = out_name_reg;

        ram_we    = 1'b0;
        ram_waddr = widx_reg;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_reg);
        ram_raddr = scan_addr_reg[AW-1:0];
        s_ready   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = s_kind;
                    name_next  = s_entry_name;
                    ext_next   = s_entry_ext;
                    mark_next  = s_mark_number;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                found_next = 1'b0;
                hit_next   = 1'b0;
                case (kind_reg)
                    KIND_SCAN: begin
                        num_next   = dec_value;
                        hit_next   = form_ok && (dec_value <= NUM_W'(MAX_NUMBER));
                        state_next = (form_ok && (dec_value <= NUM_W'(MAX_NUMBER))) ?
                                     ST_DIV : ST_RESP;
                    end
                    KIND_MARK: begin
                        num_next   = mark_reg;
                        hit_next   = mark_reg <= NUM_W'(MAX_NUMBER);
                        state_next = (mark_reg <= NUM_W'(MAX_NUMBER)) ? ST_DIV : ST_RESP;
                    end
                    KIND_ALLOC: begin
                        scan_addr_next = '0;
                        state_next     = avail_reg ? ST_SCAN : ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_DIV: begin
                prod_next  = PW'(num_reg) * PW'(RECIP);
                state_next = ST_READ;
            end
            ST_READ: begin
                ram_raddr  = widx_calc;
                widx_next  = widx_calc;
                bit_next   = bit_calc[BW-1:0];
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                if (scan_addr_reg < CW'(NUM_WORDS)) begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
                if (chk_valid_reg) begin
                    if (zero_found) begin
                        found_next     = 1'b1;
                        num_next       = NUM_W'(NUM_W'(chk_addr_reg) * NUM_W'(WORD_BITS)) +
                                         NUM_W'(zero_idx);
                        rem_next       = NUM_W'(NUM_W'(chk_addr_reg) * NUM_W'(WORD_BITS)) +
                                         NUM_W'(zero_idx);
                        dcnt_next      = 2'd0;
                        chk_valid_next = 1'b0;
                        state_next     = ST_CONV;
                    end else if (chk_addr_reg == LAST_ADDR) begin
                        avail_next     = 1'b0;
                        chk_valid_next = 1'b0;
                        state_next     = ST_RESP;
                    end
                end
            end
            ST_CONV: begin
                dig_next[dcnt_reg] = digit;
                rem_next  = rem_reg - NUM_W'(NUM_W'(digit) * place);
                dcnt_next = dcnt_reg + 2'd1;
                if (dcnt_reg == 2'd3) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_matched_next = (kind_reg == KIND_SCAN) && hit_reg;
                    out_ok_next      = found_reg;
                    out_num_next     = found_reg ? num_reg : '0;
                    out_name_next    = found_reg ?
                        {CH_0 + 8'(dig_reg[3]), CH_0 + 8'(dig_reg[2]),
                         CH_0 + 8'(dig_reg[1]), CH_0 + 8'(dig_reg[0]),
                         CH_E, CH_L, CH_I, CH_F} : '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            avail_reg     <= 1'b1;
            m_valid_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            avail_reg     <= avail_next;
            m_valid_reg   <= m_valid_next;
            chk_valid_reg <= chk_valid_next;
        end
        kind_reg        <= kind_next;
        name_reg        <= name_next;
        ext_reg         <= ext_next;
        mark_reg        <= mark_next;
        num_reg         <= num_next;
        hit_reg         <= hit_next;
        found_reg       <= found_next;
        prod_reg        <= prod_next;
        widx_reg        <= widx_next;
        bit_reg         <= bit_next;
        scan_addr_reg   <= scan_addr_next;
        chk_addr_reg    <= chk_addr_next;
        dcnt_reg        <= dcnt_next;
        rem_reg         <= rem_next;
        dig_reg         <= dig_next;
        out_matched_reg <= out_matched_next;
        out_ok_reg      <= out_ok_next;
        out_num_reg     <= out_num_next;
        out_name_reg    <= out_name_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_name_matched  = out_matched_reg;
    assign m_alloc_ok      = out_ok_reg;
    assign m_chosen_number = out_num_reg;
    assign m_chosen_name   = out_name_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for recovery_name_number_allocator_unit. Directory
// names, direct marks, allocations and the unused kind are driven through the
// s_ channel in random bursts, while the m_ channel stalls at random. A
// shadow copy of the used-number map predicts every result.
// ----------------------------------------------------------------------------
import rnna_pkg::*;

localparam int unsigned MAX_NUM     = 9999;
localparam kind_t       KIND_UNUSED = 2'd3;
localparam logic [23:0] EXT_CHK     = {CH_K, CH_H, CH_C};
localparam logic [7:0]  CH_SLASH    = 8'h2F;
localparam logic [7:0]  CH_COLON    = 8'h3A;
localparam logic [7:0]  CASE_BIT    = 8'h20;

typedef struct packed {
    logic              name_matched;
    logic              alloc_ok;
    num_t              chosen_number;
    logic [NAME_W-1:0] chosen_name;
} reply_t;

function automatic logic [NAME_W-1:0] ascii_name(input int unsigned n);
    return {8'(CH_0 + n % 10), 8'(CH_0 + (n / 10) % 10),
            8'(CH_0 + (n / 100) % 10), 8'(CH_0 + (n / 1000) % 10),
            CH_E, CH_L, CH_I, CH_F};
endfunction

class used_number_book;
    bit     used [0:MAX_NUM];
    bit     names_left = 1'b1;
    reply_t due_replies [$];
    int     scans, matched_scans, marks, allocs, granted, refused, spares;
    int     checked, mismatches;

    function int unsigned first_free();
        for (int unsigned n = 1; n <= MAX_NUM; n++) begin
            if (!used[n]) return n;
        end
        return 0;
    endfunction

    function reply_t resolve(kind_t k, logic [NAME_W-1:0] nm, logic [EXT_W-1:0] ex,
                             num_t mk);
        reply_t      r;
        bit          form;
        int unsigned v;
        r = '0;
        case (k)
            KIND_SCAN: begin
                scans++;
                form = (nm[31:0] == {CH_E, CH_L, CH_I, CH_F}) && (ex == EXT_CHK);
                for (int i = 4; i < 8; i++) begin
                    if (nm[8*i +: 8] < CH_0 || nm[8*i +: 8] > CH_9) form = 1'b0;
                end
                if (form) begin
                    v = 1000 * int'(nm[39:32] - CH_0) + 100 * int'(nm[47:40] - CH_0)
                        + 10 * int'(nm[55:48] - CH_0) + int'(nm[63:56] - CH_0);
                    if (v <= MAX_NUM) begin
                        used[v] = 1'b1;
                        r.name_matched = 1'b1;
                        matched_scans++;
                    end
                end
            end
            KIND_MARK: begin
                marks++;
                if (mk <= MAX_NUM) used[mk] = 1'b1;
            end
            KIND_ALLOC: begin
                allocs++;
                v = names_left ? first_free() : 0;
                if (v != 0) begin
                    r.alloc_ok = 1'b1;
                    r.chosen_number = num_t'(v);
                    r.chosen_name = ascii_name(v);
                    granted++;
                end else begin
                    names_left = 1'b0;
                    refused++;
                end
            end
            default: begin
                spares++;
            end
        endcase
        return r;
    endfunction

    function void note_request(kind_t k, logic [NAME_W-1:0] nm, logic [EXT_W-1:0] ex,
                               num_t mk);
        due_replies.push_back(resolve(k, nm, ex, mk));
    endfunction

    function void check_reply(logic matched, logic ok, num_t number,
                              logic [NAME_W-1:0] name);
        reply_t want;
        checked++;
        if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: matched=%0d ok=%0d number=%0d name=%h",
                         matched, ok, number, name);
            return;
        end
        want = due_replies.pop_front();
        if (matched !== want.name_matched || ok !== want.alloc_ok ||
            number !== want.chosen_number || name !== want.chosen_name) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected matched=%0d ok=%0d number=%0d name=%h",
                         want.name_matched, want.alloc_ok, want.chosen_number,
                         want.chosen_name);
                $display("          actual   matched=%0d ok=%0d number=%0d name=%h",
                         matched, ok, number, name);
            end
        end
    endfunction

    function int outstanding();
        return due_replies.size();
    endfunction
endclass

module testbench;

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    kind_t             s_kind        = KIND_SCAN;
    logic [NAME_W-1:0] s_entry_name  = '0;
    logic [EXT_W-1:0]  s_entry_ext   = '0;
    num_t              s_mark_number = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_name_matched;
    logic              m_alloc_ok;
    num_t              m_chosen_number;
    logic [NAME_W-1:0] m_chosen_name;

    used_number_book book = new();
    int burst_left = 0;
    int rx_count   = 0;
    bit rx_stalling = 1'b0;

    recovery_name_number_allocator_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_entry_name(s_entry_name),
        .s_entry_ext(s_entry_ext),
        .s_mark_number(s_mark_number),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_name_matched(m_name_matched),
        .m_alloc_ok(m_alloc_ok),
        .m_chosen_number(m_chosen_number),
        .m_chosen_name(m_chosen_name)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("run did not finish in time");
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                book.check_reply(m_name_matched, m_alloc_ok, m_chosen_number, m_chosen_name);
            if (s_valid && s_ready)
                book.note_request(s_kind, s_entry_name, s_entry_ext, s_mark_number);
        end
    end

    // The receiver alternates ready runs with stalls; now and then a long run without stalls.
    always @(posedge aclk) begin
        if (rx_count > 0) begin
            rx_count--;
        end else begin
            rx_stalling = !rx_stalling;
            if (rx_stalling)
                rx_count = $urandom_range(0, 11);
            else
                rx_count = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 30);
        end
        m_ready <= !rx_stalling;
    end

    function automatic logic [NAME_W-1:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input kind_t k, input logic [NAME_W-1:0] nm,
                             input logic [EXT_W-1:0] ex, input num_t mk);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                gap = 0;
                burst_left = 150;
            end else begin
                gap = $urandom_range(0, 8);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_kind        <= k;
        s_entry_name  <= nm;
        s_entry_ext   <= ex;
        s_mark_number <= mk;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic scan_entry(input logic [NAME_W-1:0] nm, input logic [EXT_W-1:0] ex);
        send_item(KIND_SCAN, nm, ex, num_t'($urandom));
    endtask

    task automatic mark(input num_t n);
        send_item(KIND_MARK, random_word64(), EXT_W'($urandom), n);
    endtask

    task automatic allocate();
        send_item(KIND_ALLOC, random_word64(), EXT_W'($urandom), num_t'($urandom));
    endtask

    // Mostly just above the lowest free number, so that allocations keep moving.
    function automatic int unsigned pick_number();
        int unsigned lo;
        int          sel;
        sel = $urandom_range(0, 9);
        lo  = book.first_free();
        if (sel < 7 && lo != 0) return lo + $urandom_range(0, 24);
        if (sel < 9) return $urandom_range(0, MAX_NUM);
        return $urandom_range(0, 16383);
    endfunction

    initial begin
        int                counted;
        int                sel;
        int                pos;
        int unsigned       n;
        logic [NAME_W-1:0] nm;
        logic [EXT_W-1:0]  ex;
        logic [7:0]        b;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        allocate();
        scan_entry(ascii_name(0), EXT_CHK);
        allocate();
        scan_entry(ascii_name(1), EXT_CHK);
        allocate();
        mark(num_t'(MAX_NUM));
        mark(num_t'(MAX_NUM + 1));
        mark('1);
        scan_entry(ascii_name(MAX_NUM), EXT_CHK);
        nm = ascii_name(2);
        nm[39:32] = CH_SLASH;
        scan_entry(nm, EXT_CHK);
        nm[39:32] = CH_COLON;
        scan_entry(nm, EXT_CHK);
        scan_entry(ascii_name(2) | {8'h00, 8'h00, 8'h00, 8'h00, {4{CASE_BIT}}},
                   EXT_CHK | {3{CASE_BIT}});
        scan_entry(ascii_name(2), {CH_K - 8'd1, CH_H, CH_C});
        scan_entry('1, '1);
        scan_entry('0, '0);
        send_item(KIND_UNUSED, '1, '1, '1);
        send_item(KIND_UNUSED, '0, '0, '0);
        mark(num_t'(2));
        allocate();
        mark('0);
        mark(num_t'(1));
        send_item(KIND_ALLOC, '1, '1, '1);
        send_item(KIND_ALLOC, '0, '0, '0);

        counted = 0;
        while (counted < 770) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                allocate();
            end else if (sel < 55) begin
                mark(num_t'(pick_number()));
            end else if (sel < 85) begin
                n = pick_number();
                if (n > MAX_NUM) n = MAX_NUM;
                nm = ascii_name(n);
                ex = EXT_CHK;
                if ($urandom_range(0, 9) < 3) begin
                    pos = $urandom_range(0, 10);
                    b = (pos < 8) ? nm[8*pos +: 8] : ex[8*(pos-8) +: 8];
                    case ($urandom_range(0, 3))
                        0: b = 8'($urandom);
                        1: b = b ^ CASE_BIT;
                        2: b = CH_SLASH;
                        default: b = CH_COLON;
                    endcase
                    if (pos < 8) nm[8*pos +: 8] = b;
                    else ex[8*(pos-8) +: 8] = b;
                end
                scan_entry(nm, ex);
            end else if (sel < 95) begin
                scan_entry(random_word64(), EXT_W'($urandom));
            end else begin
                send_item(KIND_UNUSED, random_word64(), EXT_W'($urandom), num_t'($urandom));
            end
            counted++;
        end

        allocate();
        mark(num_t'(MAX_NUM));
        allocate();
        scan_entry(ascii_name(5), EXT_CHK);
        allocate();
        send_item(KIND_UNUSED, random_word64(), EXT_W'($urandom), num_t'($urandom));
        allocate();
        s_valid <= 1'b0;

        while (book.outstanding() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("covered %0d scans (%0d matched), %0d marks, %0d allocations",
                 book.scans, book.matched_scans, book.marks, book.allocs);
        $display("%0d granted, %0d refused, %0d of the unused kind; %0d results checked",
                 book.granted, book.refused, book.spares, book.checked);
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", book.mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
